### rtl/trs_pkg.sv
// Shared types, constants and helper functions for the triangle rotation sign splitter.
// No dependencies; every other file in rtl imports this package.
package trs_pkg;

  // Sequencing counter and its limits
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] CNT_TRIPLE_LAST = 4'd2;  // last vertex or pair index
  localparam logic [CNT_W-1:0] COMP_LAST       = 4'd8;  // last vertex component
  localparam logic [CNT_W-1:0] EMIT_LAST_PLAIN = 4'd2;
  localparam logic [CNT_W-1:0] EMIT_LAST_SPLIT = 4'd8;

  // Vertex component indexes used by the interpolation sequence
  localparam logic [CNT_W-1:0] COMP_QX = 4'd3;
  localparam logic [CNT_W-1:0] COMP_QW = 4'd6;

  // Normal and dot widths
  localparam int NW    = 20;
  localparam int DOT_W = 42;
  localparam int AX_W  = 34;

  // Divider for the mixing weight
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 16;
  localparam int DIV_CW = $clog2(DIV_NW + 1);
  localparam int ALPHA_W = 17;
  localparam logic [ALPHA_W-1:0] ALPHA_HALF = 17'd32768;

  // Configuration
  localparam int PADDR_W = 3;
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic signed [15:0] THR_RESET = 16'sd8192;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic signed [15:0] tu;
    logic signed [15:0] tv;
  } vtx_t;

  typedef enum logic [2:0] {
    SRC_V0 = 3'd0,
    SRC_V1 = 3'd1,
    SRC_V2 = 3'd2,
    SRC_MA = 3'd3,
    SRC_MB = 3'd4
  } src_t;

  typedef struct packed {
    src_t       src;
    logic       neg;
    logic [1:0] slot;
    logic       added;
    logic       last;
  } emit_plan_t;

  typedef struct packed {
    logic             load_slot;
    logic             load_last;
    logic             slot;
    logic             norm_en;
    logic             dot_en;
    logic             decide_en;
    logic             div_start;
    logic             alpha_load;
    logic             mul_en;
    logic             acc_en;
    logic             mix_sel;
    logic             emit_load;
    logic [CNT_W-1:0] cnt;
  } ctrl_cmd_t;

  typedef struct packed {
    logic split_now;
    logic split;
    logic div_done;
  } dp_status_t;

  // Saturating negate of one Q2.14 component
  function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] x);
    logic signed [16:0] n;
    n = -{x[15], x};
    if (n > 17'sd32767) return 16'sh7fff;
    return n[15:0];
  endfunction

  function automatic vtx_t negate_q(input vtx_t v);
    vtx_t r;
    r = v;
    r.qx = neg_sat16(v.qx);
    r.qy = neg_sat16(v.qy);
    r.qz = neg_sat16(v.qz);
    r.qw = neg_sat16(v.qw);
    return r;
  endfunction

  function automatic src_t vsrc(input logic [1:0] i);
    src_t s;
    unique case (i)
      2'd0:    s = SRC_V0;
      2'd1:    s = SRC_V1;
      default: s = SRC_V2;
    endcase
    return s;
  endfunction

  // Which vertex goes out at each step of a triangle's output run
  function automatic emit_plan_t emit_plan(input logic split, input logic [1:0] odd,
                                           input logic [CNT_W-1:0] idx);
    emit_plan_t p;
    logic [1:0] nx;
    logic [1:0] pv;
    nx = (odd == 2'd2) ? 2'd0 : odd + 2'd1;
    pv = (odd == 2'd0) ? 2'd2 : odd - 2'd1;
    p.src   = vsrc(idx[1:0]);
    p.neg   = 1'b0;
    p.slot  = idx[1:0];
    p.added = 1'b0;
    p.last  = 1'b0;
    if (!split) begin
      p.last = (idx == EMIT_LAST_PLAIN);
    end else begin
      unique case (idx)
        4'd0, 4'd1, 4'd2: begin
          if (idx[1:0] == nx) begin
            p.src = SRC_MA;
            p.neg = 1'b1;
          end else if (idx[1:0] == pv) begin
            p.src = SRC_MB;
            p.neg = 1'b1;
          end
        end
        4'd3: begin
          p.src = SRC_MA; p.slot = 2'd0; p.added = 1'b1;
        end
        4'd4: begin
          p.src = vsrc(nx); p.slot = 2'd1; p.added = 1'b1;
        end
        4'd5: begin
          p.src = vsrc(pv); p.slot = 2'd2; p.added = 1'b1;
        end
        4'd6: begin
          p.src = SRC_MB; p.slot = 2'd0; p.added = 1'b1;
        end
        4'd7: begin
          p.src = SRC_MA; p.slot = 2'd1; p.added = 1'b1;
        end
        default: begin
          p.src = vsrc(pv); p.slot = 2'd2; p.added = 1'b1; p.last = 1'b1;
        end
      endcase
    end
    return p;
  endfunction

endpackage

### rtl/trs_divider.sv
// Restoring unsigned divider, one quotient bit per cycle, for the mixing weight.
// Depends on trs_pkg.
module trs_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [trs_pkg::DIV_NW-1:0] dividend,
  input  logic [trs_pkg::DIV_DW-1:0] divisor,
  output logic                       done,
  output logic [trs_pkg::DIV_NW-1:0] quotient
);
  import trs_pkg::*;

  logic              busy;
  logic [DIV_CW-1:0] count;
  logic [DIV_DW:0]   rem;
  logic [DIV_DW-1:0] dvsr;
  logic [DIV_DW:0]   shifted;
  logic              take;

  // Trial subtract on the shifted remainder
  assign shifted = {rem[DIV_DW-1:0], quotient[DIV_NW-1]};
  assign take    = (shifted >= {1'b0, dvsr});

  // Control: count bits, pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= DIV_CW'(DIV_NW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvsr     <= divisor;
    end else if (busy) begin
      rem      <= take ? (shifted - {1'b0, dvsr}) : shifted;
      quotient <= {quotient[DIV_NW-2:0], take};
    end
  end

endmodule

### rtl/trs_datapath.sv
// Datapath: held vertices, normals, dot tests, mixed vertices and the output word register.
// Depends on trs_pkg and trs_divider.
module trs_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  trs_pkg::ctrl_cmd_t        cmd,
  output trs_pkg::dp_status_t       status,
  input  logic signed [15:0]        threshold,
  input  logic signed [31:0]        position_x,
  input  logic signed [31:0]        position_y,
  input  logic signed [31:0]        position_z,
  input  logic [63:0]               frame_rotation,
  input  logic [31:0]               texture_coord,
  output logic signed [31:0]        out_position_x,
  output logic signed [31:0]        out_position_y,
  output logic signed [31:0]        out_position_z,
  output logic [63:0]               out_frame_rotation,
  output logic [31:0]               out_texture_coord,
  output logic [1:0]                corner_slot,
  output logic                      is_added,
  output logic                      last_of_run
);
  import trs_pkg::*;

  typedef struct packed {
    logic signed [NW-1:0] x;
    logic signed [NW-1:0] y;
    logic signed [NW-1:0] z;
  } nrm_t;

  vtx_t v0, v1, v2, ma, mb;
  vtx_t in_raw, in_vtx;
  nrm_t n0, n1, n2;
  logic [2:0] dok, axn, axp;
  logic       split;
  logic [1:0] odd;
  logic [ALPHA_W-1:0] alpha;
  logic signed [51:0] prod;

  function automatic vtx_t vsel(input logic [1:0] i, input vtx_t a, input vtx_t b,
                                input vtx_t c);
    vtx_t r;
    unique case (i)
      2'd0:    r = a;
      2'd1:    r = b;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic signed [32:0] comp_get(input vtx_t v, input logic [CNT_W-1:0] k);
    logic signed [32:0] r;
    unique case (k)
      4'd0:    r = 33'(v.px);
      4'd1:    r = 33'(v.py);
      4'd2:    r = 33'(v.pz);
      4'd3:    r = 33'(v.qx);
      4'd4:    r = 33'(v.qy);
      4'd5:    r = 33'(v.qz);
      4'd6:    r = 33'(v.qw);
      4'd7:    r = 33'(v.tu);
      default: r = 33'(v.tv);
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16w(input logic signed [36:0] x);
    if (x > 37'sd32767) return 16'sh7fff;
    if (x < -37'sd32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic vtx_t comp_put(input vtx_t v, input logic [CNT_W-1:0] k,
                                    input logic signed [36:0] x);
    vtx_t r;
    r = v;
    unique case (k)
      4'd0:    r.px = x[31:0];
      4'd1:    r.py = x[31:0];
      4'd2:    r.pz = x[31:0];
      4'd3:    r.qx = sat16w(x);
      4'd4:    r.qy = sat16w(x);
      4'd5:    r.qz = sat16w(x);
      4'd6:    r.qw = sat16w(x);
      4'd7:    r.tu = x[15:0];
      default: r.tv = x[15:0];
    endcase
    return r;
  endfunction

  // Unpack the incoming word and flip quaternions with negative w
  always_comb begin
    in_raw.px = position_x;
    in_raw.py = position_y;
    in_raw.pz = position_z;
    in_raw.qx = frame_rotation[15:0];
    in_raw.qy = frame_rotation[31:16];
    in_raw.qz = frame_rotation[47:32];
    in_raw.qw = frame_rotation[63:48];
    in_raw.tu = texture_coord[15:0];
    in_raw.tv = texture_coord[31:16];
    in_vtx = in_raw.qw[15] ? negate_q(in_raw) : in_raw;
  end

  // Hold incoming vertices
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= '0;
      v1 <= '0;
    end else if (cmd.load_slot) begin
      if (cmd.slot) v1 <= in_vtx;
      else          v0 <= in_vtx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_last) v2 <= in_vtx;
  end

  // Normal of one vertex per cycle
  vtx_t nv;
  logic signed [31:0] p_xz, p_wy, p_yz, p_wx, p_xx, p_yy;
  logic signed [32:0] s_x, s_y, s_q;
  logic signed [34:0] t_z;
  nrm_t n_new;

  always_comb begin
    nv   = vsel(cmd.cnt[1:0], v0, v1, v2);
    p_xz = nv.qx * nv.qz;
    p_wy = nv.qw * nv.qy;
    p_yz = nv.qy * nv.qz;
    p_wx = nv.qw * nv.qx;
    p_xx = nv.qx * nv.qx;
    p_yy = nv.qy * nv.qy;
    s_x  = 33'(p_xz) + 33'(p_wy);
    s_y  = 33'(p_yz) - 33'(p_wx);
    s_q  = 33'(p_xx) + 33'(p_yy);
    t_z  = 35'sd268435456 - (35'(s_q) <<< 1);
    n_new.x = NW'(s_x >>> 13);
    n_new.y = NW'(s_y >>> 13);
    n_new.z = NW'(t_z >>> 14);
  end

  always_ff @(posedge clk) begin
    if (cmd.norm_en) begin
      unique case (cmd.cnt[1:0])
        2'd0:    n0 <= n_new;
        2'd1:    n1 <= n_new;
        default: n2 <= n_new;
      endcase
    end
  end

  // One vertex pair per cycle: normal dot against threshold, axis dot sign
  nrm_t na, nb;
  vtx_t qa, qb;
  logic signed [DOT_W-1:0] ndot, thr_ext;
  logic signed [AX_W-1:0]  adot;

  always_comb begin
    unique case (cmd.cnt[1:0])
      2'd0: begin
        na = n0; nb = n1; qa = v0; qb = v1;
      end
      2'd1: begin
        na = n0; nb = n2; qa = v0; qb = v2;
      end
      default: begin
        na = n1; nb = n2; qa = v1; qb = v2;
      end
    endcase
    ndot = (DOT_W'(na.x) * DOT_W'(nb.x)) + (DOT_W'(na.y) * DOT_W'(nb.y)) +
           (DOT_W'(na.z) * DOT_W'(nb.z));
    thr_ext = DOT_W'(threshold) <<< 14;
    adot = (AX_W'(qa.qx) * AX_W'(qb.qx)) + (AX_W'(qa.qy) * AX_W'(qb.qy)) +
           (AX_W'(qa.qz) * AX_W'(qb.qz));
  end

  always_ff @(posedge clk) begin
    if (cmd.dot_en) begin
      dok[cmd.cnt[1:0]] <= (ndot > thr_ext);
      axn[cmd.cnt[1:0]] <= adot[AX_W-1];
      axp[cmd.cnt[1:0]] <= !adot[AX_W-1] && (adot != '0);
    end
  end

  // Pick the vertex whose axis points against the other two
  logic       pat0, pat1, pat2;
  logic [1:0] odd_now;

  always_comb begin
    pat0 = axn[0] && axn[1] && axp[2];
    pat1 = axn[0] && axp[1] && axn[2];
    pat2 = axp[0] && axn[1] && axn[2];
    priority if (pat0) odd_now = 2'd0;
    else if (pat1)     odd_now = 2'd1;
    else               odd_now = 2'd2;
    status.split_now = (&dok) && (pat0 || pat1 || pat2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      split <= 1'b0;
      odd   <= 2'd0;
    end else if (cmd.decide_en) begin
      split <= status.split_now;
      odd   <= odd_now;
    end
  end

  assign status.split = split;

  // Mix endpoints: odd vertex toward its next or previous neighbor
  logic [1:0] nxt, prv;
  vtx_t va, vb;
  logic [DIV_DW-1:0] wsum;
  logic [DIV_NW-1:0] numer, quo;
  logic              div_done;

  always_comb begin
    nxt   = (odd == 2'd2) ? 2'd0 : odd + 2'd1;
    prv   = (odd == 2'd0) ? 2'd2 : odd - 2'd1;
    va    = vsel(odd, v0, v1, v2);
    vb    = vsel(cmd.mix_sel ? prv : nxt, v0, v1, v2);
    wsum  = DIV_DW'(va.qw) + DIV_DW'(vb.qw);
    numer = {va.qw, 16'd0} + DIV_NW'(wsum >> 1);
  end

  trs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (numer),
    .divisor  (wsum),
    .done     (div_done),
    .quotient (quo)
  );

  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.alpha_load) alpha <= (wsum == '0) ? ALPHA_HALF : quo[ALPHA_W-1:0];
  end

  // Interpolate one component: multiply, then round and add
  logic               is_q;
  logic signed [32:0] ca, cb;
  logic signed [33:0] a_n, dlt;
  logic signed [51:0] rnd;
  logic signed [36:0] lerp_r;

  always_comb begin
    is_q   = (cmd.cnt >= COMP_QX) && (cmd.cnt <= COMP_QW);
    ca     = comp_get(va, cmd.cnt);
    cb     = comp_get(vb, cmd.cnt);
    a_n    = is_q ? -34'(ca) : 34'(ca);
    dlt    = 34'(cb) - a_n;
    rnd    = prod + 52'sd32768;
    lerp_r = 37'(a_n) + 37'(rnd >>> 16);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= $signed({1'b0, alpha}) * dlt;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      if (cmd.mix_sel) mb <= comp_put(mb, cmd.cnt, lerp_r);
      else             ma <= comp_put(ma, cmd.cnt, lerp_r);
    end
  end

  // Output word register
  emit_plan_t plan;
  vtx_t       ev, ev_n;

  always_comb begin
    plan = emit_plan(split, odd, cmd.cnt);
    unique case (plan.src)
      SRC_V0:  ev = v0;
      SRC_V1:  ev = v1;
      SRC_V2:  ev = v2;
      SRC_MA:  ev = ma;
      default: ev = mb;
    endcase
    ev_n = plan.neg ? negate_q(ev) : ev;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_position_x     <= ev_n.px;
      out_position_y     <= ev_n.py;
      out_position_z     <= ev_n.pz;
      out_frame_rotation <= {ev_n.qw, ev_n.qz, ev_n.qy, ev_n.qx};
      out_texture_coord  <= {ev_n.tv, ev_n.tu};
      corner_slot        <= plan.slot;
      is_added           <= plan.added;
      last_of_run        <= plan.last;
    end
  end

endmodule

### rtl/trs_ctrl.sv
// Controller: corner phase, sequencing of normal, dot, divide and interpolation steps,
// and the output word handshake. Depends on trs_pkg.
module trs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output trs_pkg::ctrl_cmd_t  cmd,
  input  trs_pkg::dp_status_t status
);
  import trs_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_NORM   = 9'b000000010,
    ST_DOT    = 9'b000000100,
    ST_DECIDE = 9'b000001000,
    ST_DIVGO  = 9'b000010000,
    ST_DIV    = 9'b000100000,
    ST_MUL    = 9'b001000000,
    ST_ACC    = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       corner_phase, corner_phase_next;
  logic             mix_sel, mix_sel_next;
  logic             out_valid_next;
  logic             emit_room;
  logic [CNT_W-1:0] emit_last;

  assign in_stall  = (state != ST_IDLE);
  assign emit_room = !out_valid || !out_stall;
  assign emit_last = status.split ? EMIT_LAST_SPLIT : EMIT_LAST_PLAIN;

  // Next state and commands
  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    corner_phase_next = corner_phase;
    mix_sel_next      = mix_sel;
    cmd               = '0;
    cmd.cnt           = cnt;
    cmd.mix_sel       = mix_sel;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (corner_phase[1]) begin
            cmd.load_last     = 1'b1;
            corner_phase_next = 2'd0;
            cnt_next          = '0;
            state_next        = ST_NORM;
          end else begin
            cmd.load_slot     = 1'b1;
            cmd.slot          = corner_phase[0];
            corner_phase_next = corner_phase + 2'd1;
          end
        end
      end
      ST_NORM: begin
        cmd.norm_en = 1'b1;
        if (cnt == CNT_TRIPLE_LAST) begin
          cnt_next   = '0;
          state_next = ST_DOT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DOT: begin
        cmd.dot_en = 1'b1;
        if (cnt == CNT_TRIPLE_LAST) begin
          cnt_next   = '0;
          state_next = ST_DECIDE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DECIDE: begin
        cmd.decide_en = 1'b1;
        mix_sel_next  = 1'b0;
        state_next    = status.split_now ? ST_DIVGO : ST_EMIT;
      end
      ST_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.alpha_load = 1'b1;
          cnt_next       = '0;
          state_next     = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        if (cnt == COMP_LAST) begin
          cnt_next = '0;
          if (mix_sel) begin
            state_next = ST_EMIT;
          end else begin
            mix_sel_next = 1'b1;
            state_next   = ST_DIVGO;
          end
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = ST_MUL;
        end
      end
      default: begin
        if (emit_room) begin
          cmd.emit_load = 1'b1;
          if (cnt == emit_last) begin
            cnt_next   = '0;
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
    endcase
    out_valid_next = cmd.emit_load ? 1'b1 : (out_valid && out_stall);
  end

  // Advance control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      corner_phase <= 2'd0;
      mix_sel      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      corner_phase <= corner_phase_next;
      mix_sel      <= mix_sel_next;
      out_valid    <= out_valid_next;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    corner_phase != 2'd3)
    else $error("corner phase out of range");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= COMP_LAST)
    else $error("step counter out of range");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && !status.div_done) |=> state == ST_DIV)
    else $error("left divide wait before quotient ready");

  a_word_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("output word raised outside emit step");

endmodule

### rtl/triangle_rotation_sign_splitter_unit.sv
// Top level of the triangle rotation sign splitter: register port, controller, datapath.
// Depends on trs_pkg, trs_ctrl, trs_datapath (and trs_divider below it).
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  input   | in_valid / in_stall   | position_x/y/z, frame_rotation, texture_coord
//  output  | out_valid / out_stall | out_position_x/y/z, out_frame_rotation,
//          |                       | out_texture_coord, corner_slot, is_added,
//          |                       | last_of_run
//  config  | psel/penable/pready   | paddr, pwdata, prdata
//
// First and second vertex of a triangle: held, no output.
// Third vertex: normals, then pair dot tests, then a decision, then 3 output words.
// Split triangle: two mixes, each a divide (one quotient bit per cycle) and then a
// multiply and an accumulate step per component on the shared multiplier, then 9 output words.
// Synchronous active-high reset clears control state and sets the threshold to 0.5.
// Input stalls while a triangle is in work; output stalls hold the output word and pause the output run.
module triangle_rotation_sign_splitter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trs_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            position_x,
  input  logic signed [31:0]            position_y,
  input  logic signed [31:0]            position_z,
  input  logic [63:0]                   frame_rotation,
  input  logic [31:0]                   texture_coord,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_position_x,
  output logic signed [31:0]            out_position_y,
  output logic signed [31:0]            out_position_z,
  output logic [63:0]                   out_frame_rotation,
  output logic [31:0]                   out_texture_coord,
  output logic [1:0]                    corner_slot,
  output logic                          is_added,
  output logic                          last_of_run
);
  import trs_pkg::*;

  logic signed [15:0] threshold;
  ctrl_cmd_t          cmd;
  dp_status_t         status;

  assign pready = 1'b1;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
      threshold <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_THRESHOLD) ? {{16{threshold[15]}}, threshold} : 32'd0;

  trs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  trs_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .threshold          (threshold),
    .position_x         (position_x),
    .position_y         (position_y),
    .position_z         (position_z),
    .frame_rotation     (frame_rotation),
    .texture_coord      (texture_coord),
    .out_position_x     (out_position_x),
    .out_position_y     (out_position_y),
    .out_position_z     (out_position_z),
    .out_frame_rotation (out_frame_rotation),
    .out_texture_coord  (out_texture_coord),
    .corner_slot        (corner_slot),
    .is_added           (is_added),
    .last_of_run        (last_of_run)
  );

endmodule

### test/triangle_rotation_sign_splitter_unit_test.sv
`timescale 1ns / 100ps
// Testbench for the triangle rotation sign splitter: directed table plus random triangles.
// Depends on trs_pkg and triangle_rotation_sign_splitter_unit; checks every output word.
module triangle_rotation_sign_splitter_unit_test;
  import trs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct {
    logic [31:0] px, py, pz;
    logic [63:0] rot;
    logic [31:0] tex;
    logic [1:0]  slot;
    logic        added;
    logic        last;
  } word_t;

  typedef struct {
    longint p[3];
    longint q[4];
    longint t[2];
  } vert_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] position_x = '0, position_y = '0, position_z = '0;
  logic [63:0] frame_rotation = '0;
  logic [31:0] texture_coord = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_position_x, out_position_y, out_position_z;
  logic [63:0] out_frame_rotation;
  logic [31:0] out_texture_coord;
  logic [1:0] corner_slot;
  logic is_added, last_of_run;

  triangle_rotation_sign_splitter_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  vert_t  held_vert[2];
  int     phase;
  longint threshold;
  word_t  expected_words[$];
  int     mismatch_count = 0;
  int     idle_pct = 23;
  int     quiet_cycles = 0;

  function automatic longint sx(logic [63:0] v, int w);
    longint r;
    r = longint'(v << (64 - w));
    return r >>> (64 - w);
  endfunction

  function automatic longint fdiv(longint v, longint d);
    if (v >= 0) return v / d;
    return -((-v + d - 1) / d);
  endfunction

  function automatic longint sat(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic vert_t negq(vert_t v);
    for (int k = 0; k < 4; k++) v.q[k] = sat(-v.q[k]);
    return v;
  endfunction

  function automatic longint lerp(longint a, longint x, longint y);
    return fdiv(a * y + (65536 - a) * x + 32768, 65536);
  endfunction

  function automatic vert_t blend(vert_t a, vert_t b);
    vert_t r;
    longint s, al;
    s = a.q[3] + b.q[3];
    al = (s <= 0) ? 32768 : (a.q[3] * 65536 + s / 2) / s;
    for (int k = 0; k < 3; k++) r.p[k] = lerp(al, a.p[k], b.p[k]);
    for (int k = 0; k < 4; k++) r.q[k] = sat(lerp(al, -a.q[k], b.q[k]));
    for (int k = 0; k < 2; k++) r.t[k] = lerp(al, a.t[k], b.t[k]);
    return r;
  endfunction

  function automatic void queue_word(vert_t v, int slot, bit added, bit last);
    word_t w;
    w.px = v.p[0][31:0];
    w.py = v.p[1][31:0];
    w.pz = v.p[2][31:0];
    for (int k = 0; k < 4; k++) w.rot[16*k +: 16] = v.q[k][15:0];
    w.tex = {v.t[1][15:0], v.t[0][15:0]};
    w.slot = slot[1:0];
    w.added = added;
    w.last = last;
    expected_words = {expected_words, w};
  endfunction

  // Work out the words caused by one accepted vertex
  function automatic void predict_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                         logic [63:0] rot, logic [31:0] tex);
    vert_t c, mA, mB;
    vert_t v[3];
    vert_t r[3];
    longint n[3][3];
    longint d01, d02, d12, thr;
    int odd, nx, pv;
    c.p[0] = sx(x, 32); c.p[1] = sx(y, 32); c.p[2] = sx(z, 32);
    for (int k = 0; k < 4; k++) c.q[k] = sx(rot >> (16 * k), 16);
    for (int k = 0; k < 2; k++) c.t[k] = sx(tex >> (16 * k), 16);
    if (c.q[3] < 0) c = negq(c);
    if (phase < 2) begin
      held_vert[phase] = c;
      phase++;
      return;
    end
    phase = 0;
    v[0] = held_vert[0]; v[1] = held_vert[1]; v[2] = c;
    for (int k = 0; k < 3; k++) begin
      n[k][0] = fdiv(2 * (v[k].q[0] * v[k].q[2] + v[k].q[3] * v[k].q[1]), 16384);
      n[k][1] = fdiv(2 * (v[k].q[1] * v[k].q[2] - v[k].q[3] * v[k].q[0]), 16384);
      n[k][2] = fdiv((64'sd1 << 28) - 2 * (v[k].q[0] * v[k].q[0] + v[k].q[1] * v[k].q[1]),
                     16384);
    end
    thr = threshold * 16384;
    odd = -1;
    if (n[0][0]*n[1][0] + n[0][1]*n[1][1] + n[0][2]*n[1][2] > thr &&
        n[0][0]*n[2][0] + n[0][1]*n[2][1] + n[0][2]*n[2][2] > thr &&
        n[1][0]*n[2][0] + n[1][1]*n[2][1] + n[1][2]*n[2][2] > thr) begin
      d01 = v[0].q[0]*v[1].q[0] + v[0].q[1]*v[1].q[1] + v[0].q[2]*v[1].q[2];
      d02 = v[0].q[0]*v[2].q[0] + v[0].q[1]*v[2].q[1] + v[0].q[2]*v[2].q[2];
      d12 = v[1].q[0]*v[2].q[0] + v[1].q[1]*v[2].q[1] + v[1].q[2]*v[2].q[2];
      if (d01 < 0 && d02 < 0 && d12 > 0) odd = 0;
      else if (d01 < 0 && d02 > 0 && d12 < 0) odd = 1;
      else if (d01 > 0 && d02 < 0 && d12 < 0) odd = 2;
    end
    if (odd < 0) begin
      for (int k = 0; k < 3; k++) queue_word(v[k], k, 1'b0, k == 2);
      return;
    end
    nx = (odd + 1) % 3;
    pv = (odd + 2) % 3;
    mA = blend(v[odd], v[nx]);
    mB = blend(v[odd], v[pv]);
    r[odd] = v[odd];
    r[nx] = negq(mA);
    r[pv] = negq(mB);
    for (int k = 0; k < 3; k++) queue_word(r[k], k, 1'b0, 1'b0);
    queue_word(mA, 0, 1'b1, 1'b0);
    queue_word(v[nx], 1, 1'b1, 1'b0);
    queue_word(v[pv], 2, 1'b1, 1'b0);
    queue_word(mB, 0, 1'b1, 1'b0);
    queue_word(mA, 1, 1'b1, 1'b0);
    queue_word(v[pv], 2, 1'b1, 1'b1);
  endfunction

  // Compare each output word with the oldest expected word
  always @(posedge clk) begin
    word_t e;
    if (!rst && (in_valid && !in_stall || out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected output word %h", out_frame_rotation);
      end else begin
        e = expected_words.pop_front();
        if (out_position_x !== e.px || out_position_y !== e.py ||
            out_position_z !== e.pz || out_frame_rotation !== e.rot ||
            out_texture_coord !== e.tex || corner_slot !== e.slot ||
            is_added !== e.added || last_of_run !== e.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp %h %h %h %h %h %0d %b %b got %h %h %h %h %h %0d %b %b",
                     e.px, e.py, e.pz, e.rot, e.tex, e.slot, e.added, e.last,
                     out_position_x, out_position_y, out_position_z, out_frame_rotation,
                     out_texture_coord, corner_slot, is_added, last_of_run);
        end
      end
    end
  end

  // Random output stall
  always @(negedge clk) out_stall <= ($urandom_range(99) < idle_pct);

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Hand one vertex to the block and wait for it to be taken
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [63:0] rot, logic [31:0] tex);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    position_x <= x; position_y <= y; position_z <= z;
    frame_rotation <= rot; texture_coord <= tex;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_vertex(x, y, z, rot, tex);
    @(negedge clk);
  endtask

  task automatic write_threshold(logic [15:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= PADDR_W'(REG_THRESHOLD) << 2;
    pwdata <= {{16{value[15]}}, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    threshold = sx(value, 16);
  endtask

  // Drop the input word and wait until every expected word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random quaternion near a base axis, w sign random, optionally axis flipped
  function automatic logic [63:0] near_quat(bit flip);
    logic signed [15:0] qx, qy, qz, qw;
    qx = 16'($urandom_range(800) - 400);
    qy = 16'($urandom_range(800) - 400);
    qz = 16'(9000 + $urandom_range(2000));
    qw = 16'(12000 + $urandom_range(3000));
    if (flip) begin
      qx = -qx; qy = -qy; qz = -qz;
    end
    if ($urandom_range(1)) begin
      qx = -qx; qy = -qy; qz = -qz; qw = -qw;
    end
    return {qw, qz, qy, qx};
  endfunction

  typedef struct {
    logic [31:0] x, y, z;
    logic [63:0] rot;
    logic [31:0] tex;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    '{32'h0, 32'h0, 32'h0, 64'h0, 32'h0},
    '{32'h7fffffff, 32'h80000000, 32'hffffffff, 64'h8000_8000_8000_8000, 32'h8000_7fff},
    '{32'h80000000, 32'h7fffffff, 32'h1, 64'h7fff_7fff_7fff_7fff, 32'h7fff_8000},
    // one odd vertex against two: split expected
    '{32'h10000, 32'h0, 32'h0, 64'h3000_2800_0100_0080, 32'h1000_0000},
    '{32'h0, 32'h10000, 32'h0, 64'h3200_d800_ff00_ff80, 32'h0000_1000},
    '{32'h0, 32'h0, 32'h10000, 64'h3100_2900_0080_0100, 32'h1000_1000},
    // both w zero at the odd vertex pair
    '{32'h0, 32'h0, 32'h0, 64'h0000_4000_0000_0000, 32'h0},
    '{32'h20000, 32'h0, 32'h0, 64'h0000_c000_0000_0000, 32'hffff_ffff},
    '{32'h0, 32'h20000, 32'h0, 64'h0000_c000_0000_0000, 32'h0001_0001},
    // axis dot exactly zero: passes unchanged
    '{32'h5, 32'h6, 32'h7, 64'h4000_0000_0000_0000, 32'h1234_5678},
    '{32'h8, 32'h9, 32'ha, 64'h4000_0000_0000_0000, 32'h9abc_def0},
    '{32'hb, 32'hc, 32'hd, 64'h4000_0000_0000_0000, 32'h5555_aaaa}
  };

  initial begin
    logic [63:0] q0, q1, q2;
    int odd;
    logic [15:0] thr_set[4] = '{16'hc000, 16'h4000, 16'h0000, 16'h2000};
    held_vert[0] = '{default: 0};
    held_vert[1] = '{default: 0};
    phase = 0;
    threshold = 8192;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                  directed_rows[i].rot, directed_rows[i].tex);
    // sender holds off until the block is empty
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(thr_set[ph]);
      idle_pct = (ph == 1) ? 0 : 23;
      for (int t = 0; t < 10; t++) begin
        odd = $urandom_range(3);
        if ($urandom_range(9) < 7) begin
          q0 = near_quat(odd == 0); q1 = near_quat(odd == 1); q2 = near_quat(odd == 2);
        end else begin
          q0 = {$urandom, $urandom}; q1 = {$urandom, $urandom}; q2 = {$urandom, $urandom};
        end
        send_vertex($urandom, $urandom, $urandom, q0, $urandom);
        send_vertex($urandom, $urandom, $urandom, q1, $urandom);
        send_vertex($urandom, $urandom, $urandom, q2, $urandom);
      end
      wait_drained();
    end
    write_threshold(16'h4000);
    wait_drained();

    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
